@@ sv/prpc_pkg.sv @@
// ----------------------------------------------------------------------------
// prpc_pkg: shared types and constants of the page range permission check
// Holds item kinds, result codes, entry bit layout, the request and result
// records passed between the top level and the walker, and the defaults of
// the top-level parameters.
// ----------------------------------------------------------------------------
`default_nettype none

package prpc_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned ENT_W  = 4;

  localparam int unsigned      PAGE_SHIFT_DEF  = 13;
  localparam logic [32:0]      KERNEL_BASE     = 33'd0;
  localparam logic [32:0]      USER_BASE_DEF   = 33'd1048576;
  localparam logic [32:0]      USER_SIZE_DEF   = 33'd1048576;
  localparam int unsigned      TABLE_PAGES_DEF = 128;

  // Entry layout: valid on top, read/write/exec permissions below.
  localparam int unsigned ENT_VALID_BIT = 3;

  typedef enum logic [1:0] {
    KIND_CHECK    = 2'd0,
    KIND_WR_KERN  = 2'd1,
    KIND_WR_USER  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DENIED  = 2'd1,
    ST_INVALID = 2'd2,
    ST_PERM    = 2'd3
  } status_e;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] length;
    logic [2:0]        need;
    logic              kern;
  } check_req_t;

  typedef struct packed {
    logic    valid;
    status_e status;
  } check_res_t;

endpackage

`default_nettype wire

@@ sv/page_range_permission_check_top.sv @@
// ----------------------------------------------------------------------------
// page_range_permission_check_top: page range permission checker
// Two page tables (kernel region 0, user region 1) with valid and
// read/write/exec bits per page; checks byte ranges against them.
// ----------------------------------------------------------------------------
// Usage:
//   Drive an item on the *_i payload ports with start high; the transfer
//   happens at the rising edge where start is high and busy is low.
//   kind_i selects a range check or a write of a kernel or user entry.
//   Entry writes give no result. Unknown kinds are dropped.
//   A range check raises done_o for exactly one cycle with status_o.
//   A check is decided without a walk when the range has zero length, lies
//   above region 1 or is kernel denied; otherwise the walker reads one page
//   entry per cycle from the single read port of the table memory, which
//   sets the rate. busy drops in the cycle done_o rises, so the next item
//   can transfer then.
//   Reset: both tables are cleared to invalid by a sweep over all
//   2*2^clog2(TABLE_PAGES) memory words (256 at the default size), one entry per
//   cycle, with busy high throughout.
//   The receiver cannot stall: each result is on status_o only while done_o
//   is high.
// ----------------------------------------------------------------------------
`default_nettype none

module page_range_permission_check_top #(
  parameter int unsigned PAGE_SHIFT  = prpc_pkg::PAGE_SHIFT_DEF,
  parameter logic [32:0] USER_BASE   = prpc_pkg::USER_BASE_DEF,
  parameter logic [32:0] USER_SIZE   = prpc_pkg::USER_SIZE_DEF,
  parameter int unsigned TABLE_PAGES = prpc_pkg::TABLE_PAGES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [1:0]  kind_i,
  input  wire logic [31:0] address_i,
  input  wire logic [31:0] length_i,
  input  wire logic        need_read_i,
  input  wire logic        need_write_i,
  input  wire logic        need_exec_i,
  input  wire logic        kernel_allowed_i,
  input  wire logic [6:0]  entry_index_i,
  input  wire logic        entry_valid_i,
  input  wire logic [2:0]  entry_perms_i,
  output      logic        done_o,
  output      logic [1:0]  status_o
);

  localparam int unsigned IDX_W   = $clog2(TABLE_PAGES);
  localparam int unsigned MEM_AW  = IDX_W + 1;
  localparam int unsigned MEM_DEP = 2 ** MEM_AW;

  // Clear sweep after reset: walk every memory word once.
  logic              clr_active_q, clr_active_d;
  logic [MEM_AW-1:0] clr_addr_q, clr_addr_d;

  logic accept, is_write, idx_ok, go, walk_busy;
  logic [IDX_W+6:0]  idx_ext;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [prpc_pkg::ENT_W-1:0] mem_wdata, mem_rdata;

  prpc_pkg::check_req_t req;
  prpc_pkg::check_res_t res;

  assign busy     = clr_active_q | walk_busy;
  assign accept   = start & ~busy;
  assign is_write = (kind_i == prpc_pkg::KIND_WR_KERN) || (kind_i == prpc_pkg::KIND_WR_USER);
  assign go       = accept & (kind_i == prpc_pkg::KIND_CHECK);

  // Drop writes to indexes beyond the table.
  assign idx_ext  = (IDX_W + 7)'(entry_index_i);
  assign idx_ok   = {25'd0, entry_index_i} < 32'(TABLE_PAGES);

  assign clr_active_d = clr_active_q & (clr_addr_q != {MEM_AW{1'b1}});
  assign clr_addr_d   = clr_addr_q + MEM_AW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else begin
      clr_active_q <= clr_active_d;
      if (clr_active_q) begin
        clr_addr_q <= clr_addr_d;
      end
    end
  end

  // Share the write port between the clear sweep and entry writes.
  always_comb begin
    if (clr_active_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_q;
      mem_wdata = '0;
    end else begin
      mem_we    = accept & is_write & idx_ok;
      mem_waddr = {kind_i == prpc_pkg::KIND_WR_USER, idx_ext[IDX_W-1:0]};
      mem_wdata = {entry_valid_i, entry_perms_i};
    end
  end

  assign req.address = address_i;
  assign req.length  = length_i;
  assign req.need    = {need_exec_i, need_write_i, need_read_i};
  assign req.kern    = kernel_allowed_i;

  prpc_ram #(
    .WIDTH (prpc_pkg::ENT_W),
    .DEPTH (MEM_DEP)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  prpc_walk #(
    .PAGE_SHIFT  (PAGE_SHIFT),
    .USER_BASE   (USER_BASE),
    .USER_SIZE   (USER_SIZE),
    .TABLE_PAGES (TABLE_PAGES)
  ) u_walk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .go_i      (go),
    .req_i     (req),
    .rd_data_i (mem_rdata),
    .rd_addr_o (mem_raddr),
    .busy_o    (walk_busy),
    .res_o     (res)
  );

  assign done_o   = res.valid;
  assign status_o = res.status;

  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !accept)
    else $error("item accepted during clear sweep");

  a_clear_ends_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clr_active_q |=> !clr_active_q)
    else $error("clear sweep restarted without reset");

  a_done_not_busy_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !walk_busy || $past(accept))
    else $error("result while walker still busy");

endmodule

`default_nettype wire

@@ sv/prpc_ram.sv @@
// ----------------------------------------------------------------------------
// prpc_ram: generic simple dual-port RAM
// One write port, one read port with the read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module prpc_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ sv/prpc_walk.sv @@
// ----------------------------------------------------------------------------
// prpc_walk: range classification and page table walker
// Classifies a check request; unless that settles it, reads one table entry
// per cycle from the first page of the range to the last, stopping at the first failing page.
// ----------------------------------------------------------------------------
`default_nettype none

module prpc_walk #(
  parameter int unsigned PAGE_SHIFT  = prpc_pkg::PAGE_SHIFT_DEF,
  parameter logic [32:0] USER_BASE   = prpc_pkg::USER_BASE_DEF,
  parameter logic [32:0] USER_SIZE   = prpc_pkg::USER_SIZE_DEF,
  parameter int unsigned TABLE_PAGES = prpc_pkg::TABLE_PAGES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            go_i,
  input  wire prpc_pkg::check_req_t            req_i,
  input  wire logic [prpc_pkg::ENT_W-1:0]      rd_data_i,
  output      logic [$clog2(TABLE_PAGES):0]    rd_addr_o,
  output      logic                            busy_o,
  output      prpc_pkg::check_res_t            res_o
);

  localparam int unsigned IDX_W  = $clog2(TABLE_PAGES);
  localparam int unsigned PAGE_W = 33 - PAGE_SHIFT;
  localparam logic [32:0] USER_END = USER_BASE + USER_SIZE;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CALC  = 4'b0010,
    S_SETUP = 4'b0100,
    S_WALK  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [prpc_pkg::ADDR_W-1:0] addr_q, len_q;
  logic [2:0]                  need_q;
  logic                        kern_q;
  logic [32:0]                 end_q, end_d;
  logic                        zero_q, above_q, below_q;
  logic [PAGE_W-1:0]           page_q, page_d, last_q, last_d;
  logic                        res_valid_q, res_valid_d;
  prpc_pkg::status_e           res_status_q, res_status_d;

  logic [32:0]       base, off_first, off_last;
  logic [PAGE_W-1:0] page_first, page_inc, page_nxt;
  logic              ent_valid;
  logic              perm_ok;

  assign base       = below_q ? prpc_pkg::KERNEL_BASE : USER_BASE;
  assign off_first  = {1'b0, addr_q} - base;
  assign off_last   = end_q - base;
  assign page_first = off_first[32:PAGE_SHIFT];
  assign page_inc   = page_q + PAGE_W'(1);
  assign page_nxt   = (state_q == S_SETUP) ? page_first : page_inc;
  assign end_d      = {1'b0, addr_q} + {1'b0, len_q} - 33'd1;

  // Kernel table sits in the lower half of the memory, user table above.
  assign rd_addr_o  = {~below_q, page_nxt[IDX_W-1:0]};

  assign ent_valid  = rd_data_i[prpc_pkg::ENT_VALID_BIT];
  assign perm_ok    = (rd_data_i[2:0] & need_q) == need_q;

  always_comb begin
    state_d      = state_q;
    page_d       = page_q;
    last_d       = last_q;
    res_valid_d  = 1'b0;
    res_status_d = res_status_q;
    unique case (state_q)
      S_IDLE: begin
        if (go_i) begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        state_d = S_SETUP;
      end
      S_SETUP: begin
        priority if (zero_q || above_q) begin
          res_valid_d  = 1'b1;
          res_status_d = prpc_pkg::ST_OK;
          state_d      = S_IDLE;
        end else if (below_q && !kern_q) begin
          res_valid_d  = 1'b1;
          res_status_d = prpc_pkg::ST_DENIED;
          state_d      = S_IDLE;
        end else if (below_q && ({1'b0, addr_q} < prpc_pkg::KERNEL_BASE)) begin
          res_valid_d  = 1'b1;
          res_status_d = prpc_pkg::ST_INVALID;
          state_d      = S_IDLE;
        end else begin
          page_d  = page_first;
          last_d  = off_last[32:PAGE_SHIFT];
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        priority if (page_q >= PAGE_W'(TABLE_PAGES) || !ent_valid) begin
          res_valid_d  = 1'b1;
          res_status_d = prpc_pkg::ST_INVALID;
          state_d      = S_IDLE;
        end else if (!perm_ok) begin
          res_valid_d  = 1'b1;
          res_status_d = prpc_pkg::ST_PERM;
          state_d      = S_IDLE;
        end else if (page_q >= last_q) begin
          res_valid_d  = 1'b1;
          res_status_d = prpc_pkg::ST_OK;
          state_d      = S_IDLE;
        end else begin
          // Next entry was already requested this cycle.
          page_d = page_inc;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      res_valid_q  <= 1'b0;
      res_status_q <= prpc_pkg::ST_OK;
    end else begin
      state_q      <= state_d;
      res_valid_q  <= res_valid_d;
      res_status_q <= res_status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && go_i) begin
      addr_q <= req_i.address;
      len_q  <= req_i.length;
      need_q <= req_i.need;
      kern_q <= req_i.kern;
    end
    if (state_q == S_CALC) begin
      end_q   <= end_d;
      zero_q  <= (len_q == '0);
      above_q <= ({1'b0, addr_q} > USER_END);
      below_q <= ({1'b0, addr_q} < USER_BASE);
    end
    page_q <= page_d;
    last_q <= last_d;
  end

  assign busy_o       = (state_q != S_IDLE);
  assign res_o.valid  = res_valid_q;
  assign res_o.status = res_status_q;

  a_res_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |=> !res_valid_q)
    else $error("result strobe held for more than one cycle");

  a_go_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i |-> state_q == S_IDLE)
    else $error("check request while walker busy");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK |-> page_q <= last_q)
    else $error("walk page passed last page of range");

  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> ($past(state_q) == S_SETUP || $past(state_q) == S_WALK))
    else $error("result without setup or walk");

endmodule

`default_nettype wire

@@ verif/page_range_permission_check_top_tb.sv @@
// ----------------------------------------------------------------------------
// page_range_permission_check_top_tb: self-checking bench of the range checker
// Loads kernel and user page table entries, sends range checks against them,
// and compares every status with a predictor that keeps its own copy of both
// tables. A directed opening covers the corner cases; random table set-ups,
// each followed by checks in the same area, and random noise items make up the rest.
// ----------------------------------------------------------------------------
module page_range_permission_check_top_tb;

  localparam int              CLK_PERIOD       = 12;
  localparam int unsigned     N_PAGES          = prpc_pkg::TABLE_PAGES_DEF;
  localparam longint unsigned PAGE_BYTES       = 64'd1 << prpc_pkg::PAGE_SHIFT_DEF;
  localparam longint unsigned KERN_LO          = 64'(prpc_pkg::KERNEL_BASE);
  localparam longint unsigned USER_LO          = 64'(prpc_pkg::USER_BASE_DEF);
  localparam longint unsigned USER_HI          = 64'(prpc_pkg::USER_BASE_DEF)
                                               + 64'(prpc_pkg::USER_SIZE_DEF);
  // Kind code that the block drops without a result.
  localparam logic [1:0]      KIND_UNUSED      = 2'd3;
  localparam int unsigned     RANDOM_ITEMS     = 1450;
  localparam int unsigned     MAX_REPORTS      = 10;
  // Longest check: one entry read past the end of a table, plus overhead.
  localparam int unsigned     TRAILING_CYCLES  = N_PAGES + 16;
  localparam int unsigned     DRAIN_LIMIT      = 4000;
  localparam longint unsigned RUN_LIMIT_CYCLES = 1_000_000;

  // One pending transfer, with the idle cycles that precede it.
  typedef struct {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [31:0] length;
    logic [2:0]  need;     // bit0 read, bit1 write, bit2 exec
    logic        kern;
    logic [6:0]  index;
    logic        valid;
    logic [2:0]  perms;
    int unsigned gap;
  } page_req_t;

  logic        clk_i;
  logic        rst_ni           = 1'b0;
  logic        start            = 1'b0;
  logic        busy;
  logic [1:0]  kind_i           = '0;
  logic [31:0] address_i        = '0;
  logic [31:0] length_i         = '0;
  logic        need_read_i      = 1'b0;
  logic        need_write_i     = 1'b0;
  logic        need_exec_i      = 1'b0;
  logic        kernel_allowed_i = 1'b0;
  logic [6:0]  entry_index_i    = '0;
  logic        entry_valid_i    = 1'b0;
  logic [2:0]  entry_perms_i    = '0;
  logic        done_o;
  logic [1:0]  status_o;

  // Predictor copy of both tables: {valid, perms} per page.
  logic [3:0]  kern_pages [N_PAGES];
  logic [3:0]  user_pages [N_PAGES];

  page_req_t          pending_reqs [$];
  prpc_pkg::status_e  expected_status [$];
  page_req_t          cur_req;

  bit          idle_on = 1'b1;
  int unsigned n_counted;
  int unsigned n_fail;
  int unsigned n_checks, n_writes, n_ignored;
  int unsigned status_tally [4];

  page_range_permission_check_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .kind_i           (kind_i),
    .address_i        (address_i),
    .length_i         (length_i),
    .need_read_i      (need_read_i),
    .need_write_i     (need_write_i),
    .need_exec_i      (need_exec_i),
    .kernel_allowed_i (kernel_allowed_i),
    .entry_index_i    (entry_index_i),
    .entry_valid_i    (entry_valid_i),
    .entry_perms_i    (entry_perms_i),
    .done_o           (done_o),
    .status_o         (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Walk one table from first_pg to last_pg; the first failing page decides.
  // Pages past the end of the table read as invalid.
  function automatic prpc_pkg::status_e walk_pages(bit on_user, longint unsigned first_pg,
                                                   longint unsigned last_pg,
                                                   logic [2:0] need);
    longint unsigned pg;
    logic [3:0]      ent;
    pg = first_pg;
    forever begin
      if (pg >= N_PAGES) return prpc_pkg::ST_INVALID;
      ent = on_user ? user_pages[pg] : kern_pages[pg];
      if (!ent[prpc_pkg::ENT_VALID_BIT]) return prpc_pkg::ST_INVALID;
      if ((ent[2:0] & need) != need) return prpc_pkg::ST_PERM;
      if (pg >= last_pg) return prpc_pkg::ST_OK;
      pg++;
    end
  endfunction

  function automatic prpc_pkg::status_e range_status(page_req_t r);
    longint unsigned lo_byte;
    longint unsigned last_byte;
    lo_byte = 64'(r.address);
    if (r.length == 0) return prpc_pkg::ST_OK;
    if (lo_byte > USER_HI) return prpc_pkg::ST_OK;
    // End of range without wrap: a range past 2^32 runs off the table.
    last_byte = lo_byte + 64'(r.length) - 1;
    if (lo_byte < USER_LO || last_byte < USER_LO) begin
      if (!r.kern) return prpc_pkg::ST_DENIED;
      return walk_pages(1'b0, (lo_byte - KERN_LO) >> prpc_pkg::PAGE_SHIFT_DEF,
                        (last_byte - KERN_LO) >> prpc_pkg::PAGE_SHIFT_DEF, r.need);
    end
    return walk_pages(1'b1, (lo_byte - USER_LO) >> prpc_pkg::PAGE_SHIFT_DEF,
                      (last_byte - USER_LO) >> prpc_pkg::PAGE_SHIFT_DEF, r.need);
  endfunction

  // Update the table copy or queue the status that a transfer produces.
  task automatic apply_transfer(input page_req_t r);
    prpc_pkg::status_e st;
    if (r.kind == prpc_pkg::KIND_CHECK) begin
      st = range_status(r);
      expected_status.push_back(st);
      status_tally[st]++;
      n_checks++;
    end else if (r.kind == prpc_pkg::KIND_WR_KERN || r.kind == prpc_pkg::KIND_WR_USER) begin
      if (r.index < N_PAGES) begin
        if (r.kind == prpc_pkg::KIND_WR_KERN) kern_pages[r.index] = {r.valid, r.perms};
        else                                  user_pages[r.index] = {r.valid, r.perms};
      end
      n_writes++;
    end else begin
      n_ignored++;
    end
  endtask

  function automatic page_req_t random_fields();
    page_req_t r;
    r.kind    = 2'($urandom_range(0, 3));
    r.address = $urandom();
    r.length  = $urandom();
    r.need    = 3'($urandom_range(0, 7));
    r.kern    = 1'($urandom_range(0, 1));
    r.index   = 7'($urandom_range(0, 127));
    r.valid   = 1'($urandom_range(0, 1));
    r.perms   = 3'($urandom_range(0, 7));
    r.gap     = 0;
    return r;
  endfunction

  function automatic page_req_t mk_check(longint unsigned addr, longint unsigned len,
                                         logic [2:0] need, logic kern);
    page_req_t r;
    r         = random_fields();
    r.kind    = prpc_pkg::KIND_CHECK;
    r.address = 32'(addr);
    r.length  = 32'(len);
    r.need    = need;
    r.kern    = kern;
    return r;
  endfunction

  function automatic page_req_t mk_write(logic [1:0] kind, int unsigned idx,
                                         logic valid, logic [2:0] perms);
    page_req_t r;
    r       = random_fields();
    r.kind  = kind;
    r.index = 7'(idx);
    r.valid = valid;
    r.perms = perms;
    return r;
  endfunction

  task automatic add_req(input page_req_t r);
    r.gap = idle_on ? $urandom_range(0, 13) : 0;
    pending_reqs.push_back(r);
    if (r.kind != KIND_UNUSED) n_counted++;
  endtask

  // Driver: present the next item once the slot is free, after its idle gap.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    int unsigned hold_cnt;
    bit          hold_armed;
    page_req_t   nxt;
    if (!rst_ni) begin
      start            <= 1'b0;
      kind_i           <= '0;
      address_i        <= '0;
      length_i         <= '0;
      need_read_i      <= 1'b0;
      need_write_i     <= 1'b0;
      need_exec_i      <= 1'b0;
      kernel_allowed_i <= 1'b0;
      entry_index_i    <= '0;
      entry_valid_i    <= 1'b0;
      entry_perms_i    <= '0;
      hold_cnt          = 0;
      hold_armed        = 1'b0;
    end else begin
      // Predict on the transfer edge, using the item as it stood.
      if (start && !busy) apply_transfer(cur_req);
      // Hold the item while the block is busy; otherwise advance.
      if (!start || !busy) begin
        if (pending_reqs.size() == 0) begin
          start <= 1'b0;
        end else begin
          if (!hold_armed) begin
            hold_cnt   = pending_reqs[0].gap;
            hold_armed = 1'b1;
          end
          if (hold_cnt != 0) begin
            hold_cnt--;
            start <= 1'b0;
          end else begin
            nxt              = pending_reqs.pop_front();
            cur_req          = nxt;
            hold_armed       = 1'b0;
            start            <= 1'b1;
            kind_i           <= nxt.kind;
            address_i        <= nxt.address;
            length_i         <= nxt.length;
            need_read_i      <= nxt.need[0];
            need_write_i     <= nxt.need[1];
            need_exec_i      <= nxt.need[2];
            kernel_allowed_i <= nxt.kern;
            entry_index_i    <= nxt.index;
            entry_valid_i    <= nxt.valid;
            entry_perms_i    <= nxt.perms;
          end
        end
      end
    end
  end

  // Monitor: a status is valid only in the cycle done_o is high.
  always @(posedge clk_i) begin : result_check
    prpc_pkg::status_e want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_status.size() == 0) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS)
          $display("%0t: unexpected status %0d with nothing pending", $time, status_o);
      end else begin
        want = expected_status.pop_front();
        if (status_o !== want) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display("%0t: status mismatch, expected %s (%0d), got %0d",
                     $time, want.name(), want, status_o);
        end
      end
    end
  end

  initial begin : stimulus
    page_req_t       r;
    bit              on_user;
    int unsigned     base_pg, span, n_chk, sel, drain;
    longint unsigned region_lo, start_off, len;

    foreach (kern_pages[i]) kern_pages[i] = '0;
    foreach (user_pages[i]) user_pages[i] = '0;

    // Directed part: empty tables, boundaries, each status, wrap-free ends.
    add_req(mk_check(USER_LO, 1, 3'b000, 1'b0));               // empty table
    add_req(mk_write(prpc_pkg::KIND_WR_USER, 0, 1'b1, 3'b111));
    add_req(mk_write(prpc_pkg::KIND_WR_USER, 1, 1'b1, 3'b011));
    add_req(mk_write(prpc_pkg::KIND_WR_USER, 2, 1'b1, 3'b000));
    add_req(mk_write(prpc_pkg::KIND_WR_USER, 127, 1'b1, 3'b101));
    add_req(mk_write(prpc_pkg::KIND_WR_KERN, 0, 1'b1, 3'b111));
    add_req(mk_write(prpc_pkg::KIND_WR_KERN, 127, 1'b1, 3'b001));
    add_req(mk_check(0, 0, 3'b111, 1'b0));                     // zero length
    add_req(mk_check(USER_HI + 1, 5, 3'b111, 1'b0));           // above region 1
    add_req(mk_check(32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'b111, 1'b1));
    add_req(mk_check(USER_HI, 1, 3'b000, 1'b1));               // one page past table
    add_req(mk_check(0, 1, 3'b000, 1'b0));                     // kernel denied
    add_req(mk_check(0, 1, 3'b111, 1'b1));                     // kernel walk ok
    add_req(mk_check(USER_LO - 1, 2, 3'b001, 1'b1));           // kernel runs off table
    add_req(mk_check(USER_LO, 2 * PAGE_BYTES, 3'b010, 1'b0));  // two pages ok
    add_req(mk_check(USER_LO, 2 * PAGE_BYTES, 3'b100, 1'b0));  // exec missing
    add_req(mk_check(USER_LO + 2 * PAGE_BYTES, 1, 3'b000, 1'b0));
    add_req(mk_check(USER_LO + 2 * PAGE_BYTES, 1, 3'b001, 1'b0));
    add_req(mk_check(USER_LO, 32'hFFFF_FFFF, 3'b000, 1'b0));   // long range, no wrap
    add_req(mk_check(USER_HI - 1, 1, 3'b101, 1'b0));           // last user page
    add_req(mk_write(prpc_pkg::KIND_WR_USER, 1, 1'b0, 3'b111)); // valid beats perms
    add_req(mk_check(USER_LO + PAGE_BYTES, 1, 3'b000, 1'b0));
    add_req(mk_write(KIND_UNUSED, 0, 1'b1, 3'b111));           // dropped kind
    add_req(mk_check(USER_LO - 1, 1, 3'b000, 1'b0));

    // Random part: mostly table set-ups followed by checks over the same
    // pages, with some fully random items as noise.
    n_counted = 0;
    while (n_counted < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 99) < 80) begin
        on_user   = 1'($urandom_range(0, 1));
        base_pg   = $urandom_range(0, N_PAGES - 1);
        span      = $urandom_range(1, 6);
        region_lo = on_user ? USER_LO : KERN_LO;
        for (int unsigned i = 0; i < span; i++) begin
          if (base_pg + i < N_PAGES) begin
            r       = random_fields();
            r.kind  = on_user ? prpc_pkg::KIND_WR_USER : prpc_pkg::KIND_WR_KERN;
            r.index = 7'(base_pg + i);
            r.valid = ($urandom_range(0, 99) < 85);
            r.perms = ($urandom_range(0, 9) < 7) ? 3'b111 : 3'($urandom_range(0, 7));
            add_req(r);
          end
        end
        n_chk = $urandom_range(2, 5);
        for (int unsigned j = 0; j < n_chk; j++) begin
          start_off = 64'(base_pg + $urandom_range(0, span - 1)) * PAGE_BYTES
                    + $urandom_range(0, 32'(PAGE_BYTES) - 1);
          sel = $urandom_range(0, 99);
          if (sel < 45)      len = $urandom_range(1, span * 32'(PAGE_BYTES));
          else if (sel < 65) len = $urandom_range(1, 64);
          else if (sel < 75) len = $urandom();
          else if (sel < 80) len = 0;
          else               len = $urandom_range(1, 16 * 32'(PAGE_BYTES));
          r = mk_check(region_lo + start_off, len, 3'($urandom_range(0, 7)),
                       on_user ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 99) < 85));
          add_req(r);
        end
      end else begin
        repeat ($urandom_range(1, 4)) add_req(random_fields());
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every item transferred, then every status back, then a margin
    // for anything stray.
    while (pending_reqs.size() != 0 || start) @(posedge clk_i);
    drain = 0;
    while (expected_status.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (TRAILING_CYCLES) @(posedge clk_i);
    if (expected_status.size() != 0) begin
      $display("%0d expected statuses never arrived", expected_status.size());
      n_fail += expected_status.size();
    end

    $display("Covered %0d range checks (ok %0d, denied %0d, invalid %0d, perm %0d),",
             n_checks, status_tally[prpc_pkg::ST_OK], status_tally[prpc_pkg::ST_DENIED],
             status_tally[prpc_pkg::ST_INVALID], status_tally[prpc_pkg::ST_PERM]);
    $display("%0d entry writes and %0d dropped items; %0d failures.",
             n_writes, n_ignored, n_fail);
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: stop a hung run.
  initial begin : watchdog
    #(RUN_LIMIT_CYCLES * CLK_PERIOD);
    $display("Run timed out with %0d statuses outstanding", expected_status.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
